@@ sv/distance_bond_perception_defines.svh @@
// assertion macros shared by the bond perception modules
`ifndef DISTANCE_BOND_PERCEPTION_DEFINES_SVH
`define DISTANCE_BOND_PERCEPTION_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define DBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define DBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dbp_pkg.sv @@
// shared types and constants of the bond perception block
`default_nettype none

package dbp_pkg;

    // field widths
    localparam int COORD_W    = 20;
    localparam int RADIN_W    = 13;
    localparam int RAD_W      = 12;
    localparam int ANUM_W     = 7;
    localparam int IDX_OUT_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // arithmetic widths
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 41;
    localparam int DSQ_W   = 42;
    localparam int CUT_W   = 14;
    localparam int CUTSQ_W = 2 * CUT_W;
    localparam int MINSQ_W = 2 * CFG_DATA_W;

    // element code of hydrogen
    localparam logic [ANUM_W-1:0] HYDROGEN = 7'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECTION_ONLY = 2'd2;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] TOLERANCE_RESET    = 12'd461;
    localparam logic [CFG_DATA_W-1:0] MIN_DISTANCE_RESET = 12'd328;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] tolerance;
        logic [CFG_DATA_W-1:0] min_distance;
        logic                  selection_only;
    } t_cfg;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
        logic emit_ovf;
    } t_cmd;

    // one stored atom
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [RAD_W-1:0]   radius;
        logic               hyd;
        logic               sel;
    } t_entry;

endpackage

`default_nettype wire

@@ sv/dbp_ram.sv @@
// generic single write, single read ram with registered read data
`default_nettype none

module dbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/dbp_ctrl.sv @@
// controller: atom count, scan sequencing and command generation
`default_nettype none
`include "distance_bond_perception_defines.svh"

module dbp_ctrl #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_start_new,
    input  logic                         i_pipe_busy,
    output logic                         o_busy,
    output dbp_pkg::t_cmd                o_cmd,
    output logic [$clog2(MAX_ATOMS)-1:0] o_rd_addr,
    output logic [$clog2(MAX_ATOMS)-1:0] o_wr_addr
);

    import dbp_pkg::*;

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int CW = $clog2(MAX_ATOMS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ATOMS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_OVF
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_j, n_j;
    logic [AW-1:0]   r_me, n_me;
    logic            accept;
    logic [CW-1:0]   me_c;
    logic            full;

    // accept decode and slot of the new atom
    always_comb begin
        accept = i_start && (r_state == S_IDLE);
        me_c   = i_start_new ? '0 : r_count;
        full   = (me_c == FULL_CNT);
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_j     = r_j;
        n_me    = r_me;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (full) begin
                        n_state = S_OVF;
                    end else begin
                        n_count = me_c + CW'(1);
                        n_me    = me_c[AW-1:0];
                        n_j     = '0;
                        n_state = (me_c == '0) ? S_IDLE : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_j == r_me - AW'(1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_DRAIN: begin
                if (!i_pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_OVF: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_j     <= '0;
            r_me    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_j     <= n_j;
            r_me    <= n_me;
        end
    end

    // commands to the datapath
    always_comb begin
        o_cmd.load     = accept && !full;
        o_cmd.issue    = (r_state == S_SCAN);
        o_cmd.finish   = (r_state == S_DRAIN) && !i_pipe_busy;
        o_cmd.emit_ovf = (r_state == S_OVF);
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_rd_addr = r_j;
    assign o_wr_addr = me_c[AW-1:0];

    // checks
    `DBP_ASSERT_NOW(a_issue_below_me, i_clk, i_rst_n, o_cmd.issue, o_rd_addr < r_me, "scan read at or beyond new atom")
    `DBP_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT, "atom count beyond capacity")
    `DBP_ASSERT_NEXT(a_count_after_load, i_clk, i_rst_n, o_cmd.load, r_count != '0, "store empty after load")

endmodule

`default_nettype wire

@@ sv/dbp_datapath.sv @@
// datapath: atom store, distance pipeline, bond hold and result register
`default_nettype none
`include "distance_bond_perception_defines.svh"

module dbp_datapath #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dbp_pkg::t_cfg                        i_cfg,
    input  dbp_pkg::t_cmd                        i_cmd,
    input  logic [$clog2(MAX_ATOMS)-1:0]         i_rd_addr,
    input  logic [$clog2(MAX_ATOMS)-1:0]         i_wr_addr,
    input  logic signed [dbp_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [dbp_pkg::COORD_W-1:0]   i_pos_y,
    input  logic signed [dbp_pkg::COORD_W-1:0]   i_pos_z,
    input  logic signed [dbp_pkg::RADIN_W-1:0]   i_radius,
    input  logic [dbp_pkg::ANUM_W-1:0]           i_atomic_number,
    input  logic                                 i_selected,
    output logic                                 o_pipe_busy,
    output logic                                 o_valid,
    output logic [dbp_pkg::IDX_OUT_W-1:0]        o_first_atom,
    output logic [dbp_pkg::IDX_OUT_W-1:0]        o_second_atom,
    output logic                                 o_last,
    output logic                                 o_overflow
);

    import dbp_pkg::*;

    localparam int AW = $clog2(MAX_ATOMS);

    // new atom and its store word
    t_entry               wr_entry;
    t_entry               rd_entry;
    t_entry               r_new;
    logic [AW-1:0]        r_me;
    logic [MINSQ_W-1:0]   r_min_sq;

    // scan pipeline
    logic                      r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0]             r_idx1, r_idx2, r_idx3, r_idx4;
    logic signed [DIFF_W-1:0]  r_dx2, r_dy2, r_dz2;
    logic [CUT_W-1:0]          r_cut2;
    logic [SQ_W-1:0]           r_sqx3, r_sqy3, r_sqz3;
    logic [CUTSQ_W-1:0]        r_cutsq3, r_cutsq4;
    logic [DSQ_W-1:0]          r_dsq4;

    // stage logic
    logic signed [DIFF_W-1:0]  dx, dy, dz;
    logic [CUT_W-1:0]          cut;
    logic                      skip;
    logic signed [2*DIFF_W-1:0] sqx, sqy, sqz;
    logic [CUTSQ_W-1:0]        cutsq;
    logic [DSQ_W-1:0]          dsq;
    logic                      hit;

    // held bond and result word
    logic                   r_pend_v;
    logic [AW-1:0]          r_pend_idx;
    logic                   r_out_v;
    logic [IDX_OUT_W-1:0]   r_out_first;
    logic [IDX_OUT_W-1:0]   r_out_second;
    logic                   r_out_last;
    logic                   r_out_ovf;

    // store word of the incoming atom, radius clamped at zero
    always_comb begin
        wr_entry.x      = i_pos_x;
        wr_entry.y      = i_pos_y;
        wr_entry.z      = i_pos_z;
        wr_entry.radius = i_radius[RADIN_W-1] ? '0 : i_radius[RAD_W-1:0];
        wr_entry.hyd    = (i_atomic_number == HYDROGEN);
        wr_entry.sel    = i_selected;
    end

    dbp_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_ATOMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (i_wr_addr),
        .i_wdata (wr_entry),
        .i_re    (i_cmd.issue),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_entry)
    );

    // latch new atom at load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new    <= wr_entry;
            r_me     <= i_wr_addr;
            r_min_sq <= i_cfg.min_distance * i_cfg.min_distance;
        end
    end

    // stage 1: differences, cutoff and pair filter
    always_comb begin
        dx   = $signed({r_new.x[COORD_W-1], r_new.x}) - $signed({rd_entry.x[COORD_W-1], rd_entry.x});
        dy   = $signed({r_new.y[COORD_W-1], r_new.y}) - $signed({rd_entry.y[COORD_W-1], rd_entry.y});
        dz   = $signed({r_new.z[COORD_W-1], r_new.z}) - $signed({rd_entry.z[COORD_W-1], rd_entry.z});
        cut  = CUT_W'(rd_entry.radius) + CUT_W'(r_new.radius) + CUT_W'(i_cfg.tolerance);
        skip = (i_cfg.selection_only && (!r_new.sel || !rd_entry.sel))
            || (r_new.hyd && rd_entry.hyd);
    end

    // stage 2: squares
    always_comb begin
        sqx   = r_dx2 * r_dx2;
        sqy   = r_dy2 * r_dy2;
        sqz   = r_dz2 * r_dz2;
        cutsq = r_cut2 * r_cut2;
    end

    // stage 3: sum, stage 4: window compare
    always_comb begin
        dsq = DSQ_W'(r_sqx3) + DSQ_W'(r_sqy3) + DSQ_W'(r_sqz3);
        hit = r_v4 && (r_dsq4 < DSQ_W'(r_cutsq4)) && (r_dsq4 > DSQ_W'(r_min_sq));
    end

    // pipeline valid tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1 && !skip;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_idx1   <= i_rd_addr;
        r_idx2   <= r_idx1;
        r_dx2    <= dx;
        r_dy2    <= dy;
        r_dz2    <= dz;
        r_cut2   <= cut;
        r_idx3   <= r_idx2;
        r_sqx3   <= sqx[SQ_W-1:0];
        r_sqy3   <= sqy[SQ_W-1:0];
        r_sqz3   <= sqz[SQ_W-1:0];
        r_cutsq3 <= cutsq;
        r_idx4   <= r_idx3;
        r_dsq4   <= dsq;
        r_cutsq4 <= r_cutsq3;
    end

    assign o_pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;

    // one bond is held back so the final one can carry the last flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            if (i_cmd.emit_ovf) begin
                r_out_v <= 1'b1;
            end else if (hit) begin
                r_out_v  <= r_pend_v;
                r_pend_v <= 1'b1;
            end else if (i_cmd.finish) begin
                r_out_v  <= r_pend_v;
                r_pend_v <= 1'b0;
            end
        end
    end

    // result word and held bond index
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ovf) begin
            r_out_first  <= '0;
            r_out_second <= '0;
            r_out_last   <= 1'b1;
            r_out_ovf    <= 1'b1;
        end else if (hit || i_cmd.finish) begin
            r_out_first  <= IDX_OUT_W'(r_pend_idx);
            r_out_second <= IDX_OUT_W'(r_me);
            r_out_last   <= !hit;
            r_out_ovf    <= 1'b0;
        end
        if (hit) begin
            r_pend_idx <= r_idx4;
        end
    end

    assign o_valid       = r_out_v;
    assign o_first_atom  = r_out_first;
    assign o_second_atom = r_out_second;
    assign o_last        = r_out_last;
    assign o_overflow    = r_out_ovf;

    // checks
    `DBP_ASSERT_NOW(a_ovf_is_last, i_clk, i_rst_n, o_valid && o_overflow, o_last, "overflow word without last flag")
    `DBP_ASSERT_NOW(a_load_when_clear, i_clk, i_rst_n, i_cmd.load, !o_pipe_busy && !r_pend_v, "load while previous atom still in flight")

endmodule

`default_nettype wire

@@ sv/distance_bond_perception.sv @@
// Bond perception top level: one stored atom is compared per cycle via the store read port.
// An atom with n stored atoms before it keeps busy high while they are scanned and the pipeline
// drains; its bond words come at most one per cycle, each held until the next bond or scan end.
// A dropped atom (store full) holds busy in the overflow state, then yields its overflow word.
// Synchronous active-low reset clears the atom count and controller and presets configuration;
// stored atoms are not cleared, result words cannot be held off by the receiver.
`default_nettype none

module distance_bond_perception #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dbp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dbp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_start_new,
    input  logic signed [dbp_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [dbp_pkg::COORD_W-1:0]   i_pos_y,
    input  logic signed [dbp_pkg::COORD_W-1:0]   i_pos_z,
    input  logic signed [dbp_pkg::RADIN_W-1:0]   i_radius,
    input  logic [dbp_pkg::ANUM_W-1:0]           i_atomic_number,
    input  logic                                 i_selected,
    output logic                                 o_valid,
    output logic [dbp_pkg::IDX_OUT_W-1:0]        o_first_atom,
    output logic [dbp_pkg::IDX_OUT_W-1:0]        o_second_atom,
    output logic                                 o_last,
    output logic                                 o_overflow
);

    import dbp_pkg::*;

    localparam int AW = $clog2(MAX_ATOMS);

    t_cfg           r_cfg;
    t_cmd           cmd;
    logic           pipe_busy;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance      <= TOLERANCE_RESET;
            r_cfg.min_distance   <= MIN_DISTANCE_RESET;
            r_cfg.selection_only <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOLERANCE:      r_cfg.tolerance      <= i_cfg_data;
                CFG_MIN_DISTANCE:   r_cfg.min_distance   <= i_cfg_data;
                CFG_SELECTION_ONLY: r_cfg.selection_only <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // controller
    dbp_ctrl #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_start_new (i_start_new),
        .i_pipe_busy (pipe_busy),
        .o_busy      (busy),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr)
    );

    // datapath
    dbp_datapath #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (cmd),
        .i_rd_addr       (rd_addr),
        .i_wr_addr       (wr_addr),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_radius        (i_radius),
        .i_atomic_number (i_atomic_number),
        .i_selected      (i_selected),
        .o_pipe_busy     (pipe_busy),
        .o_valid         (o_valid),
        .o_first_atom    (o_first_atom),
        .o_second_atom   (o_second_atom),
        .o_last          (o_last),
        .o_overflow      (o_overflow)
    );

endmodule

`default_nettype wire
